/* rtl/fbpa_pkg.sv */
// fbpa_pkg.sv: shared types and codes for the fixed block pool allocator
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 32;
  localparam int CAP_W    = 16;
  localparam int COUNT_W  = 7;
  localparam int ACTION_W = 3;
  // capacity plus a header of up to 64 bytes
  localparam int STRIDE_W = 17;
  localparam int CFG_IDX_W = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LENGTH = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RESIZE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESET  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SIZE_W-1:0]   size;
    logic [ADDR_W-1:0]   address;
  } cmd_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] result_address;
    logic [CAP_W-1:0]  length;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_EVAL,
    ST_SCAN,
    ST_GRANT_MUL,
    ST_GRANT_ADD,
    ST_DIV
  } state_t;

endpackage

/* rtl/fbpa_ram.sv */
// fbpa_ram.sv: generic single write port ram with registered read
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fbpa_div.sv */
// fbpa_div.sv: restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fbpa_div #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 run;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0]   shifted;
  logic                 ge;

  // trial subtract of the shifted partial remainder
  assign shifted = {remainder, quotient[DIVIDEND_W-1]};
  assign ge      = (shifted >= {1'b0, dsr});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CNT_W'(DIVIDEND_W);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (run) begin
      remainder <= ge ? DIVISOR_W'(shifted - {1'b0, dsr}) : shifted[DIVISOR_W-1:0];
      quotient  <= {quotient[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

/* rtl/fixed_block_pool_allocator_unit.sv */
// fixed_block_pool_allocator_unit.sv: top level of the fixed block pool allocator
// Length, resize, oversize allocate, unowned free and unknown actions finish from the
// evaluate state; allocate scans the free map with one memory read per chunk, then
// multiplies and adds to form the address; free runs the 32-step serial divider; reset
// clears the whole map. One word at a time; the strobe cannot be stalled.
// After rst the free map is cleared entry by entry with busy high.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_unit #(
  parameter int MAX_CHUNKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  fbpa_pkg::cmd_t                 cmd,
  output logic                           done,
  output fbpa_pkg::rsp_t                 result,
  input  logic                           cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);

  import fbpa_pkg::*;

  localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int N_W    = $clog2(MAX_CHUNKS + 1);
  localparam int SPAN_W = N_W + STRIDE_W;
  localparam int PROD_W = IDX_W + STRIDE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHUNKS - 1);

  state_t state, state_next;

  // configuration registers
  logic [ADDR_W-1:0]  base_address;
  logic [CAP_W-1:0]   chunk_capacity;
  logic [COUNT_W-1:0] chunk_count;

  // per-word registers
  cmd_t                cmd_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [SPAN_W-1:0]   span_q;
  logic [N_W-1:0]      rd_idx, rd_idx_next;
  logic [IDX_W-1:0]    chk_idx;
  logic                pend, pend_next;
  logic [IDX_W-1:0]    grant_idx;
  logic [PROD_W-1:0]   prod_q;
  logic [IDX_W-1:0]    clr_idx;
  logic                clr_reply, clr_reply_next;
  logic                done_next;
  rsp_t                rsp_next;

  // memory and divider hookups
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [0:0]        mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [0:0]        mem_rdata;
  logic              div_go;
  logic              div_done;
  logic [ADDR_W-1:0] div_quo;
  logic [STRIDE_W-1:0] div_rem;

  // combinational helpers
  logic [N_W-1:0]      n_eff;
  logic [STRIDE_W-1:0] stride_now;
  logic [ADDR_W:0]     span_hi;
  logic                owned;
  logic                issue;
  logic                found;
  logic                size_fits;
  logic                free_hit;

  // memory holds one used bit per chunk, 0 means free
  fbpa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CHUNKS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // maps an offset to a chunk slot and offset within it
  fbpa_div #(
    .DIVIDEND_W (ADDR_W),
    .DIVISOR_W  (STRIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (cmd_q.address - base_address),
    .divisor   (stride_q),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // pool geometry
  always_comb begin
    if (32'(chunk_count) > 32'(MAX_CHUNKS)) begin
      n_eff = N_W'(MAX_CHUNKS);
    end else begin
      n_eff = N_W'(chunk_count);
    end
  end

  assign stride_now = STRIDE_W'(chunk_capacity) + STRIDE_W'(HEADER_BYTES);
  assign span_hi    = (ADDR_W + 1)'(base_address) + (ADDR_W + 1)'(span_q);
  assign owned      = (cmd_q.address >= base_address) &&
                      ((ADDR_W + 1)'(cmd_q.address) < span_hi);
  assign size_fits  = (cmd_q.size <= 32'(chunk_capacity));

  // scan pipeline: issue a read, check it in the next cycle
  assign issue = (rd_idx < n_eff);
  assign found = (state == ST_SCAN) && pend && (mem_rdata == 1'b0);

  // free lands exactly on a data start inside the pool
  assign free_hit = (div_rem == STRIDE_W'(HEADER_BYTES)) && (div_quo < 32'(n_eff));

  assign busy = (state != ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        case (cmd_q.action)
          ACT_ALLOC: state_next = size_fits ? ST_SCAN : ST_IDLE;
          ACT_FREE:  state_next = owned ? ST_DIV : ST_IDLE;
          ACT_RESET: state_next = ST_CLEAR;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (found) begin
          state_next = ST_GRANT_MUL;
        end else if (!issue && !pend) begin
          state_next = ST_IDLE;
        end
      end
      ST_GRANT_MUL: begin
        state_next = ST_GRANT_ADD;
      end
      ST_GRANT_ADD: begin
        state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = 1'b0;
    mem_raddr      = rd_idx[IDX_W-1:0];
    div_go         = 1'b0;
    done_next      = 1'b0;
    rsp_next       = '0;
    rd_idx_next    = rd_idx;
    pend_next      = 1'b0;
    clr_reply_next = clr_reply;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        if (clr_idx == LAST_IDX) begin
          done_next      = clr_reply;
          rsp_next.ok    = clr_reply;
          clr_reply_next = 1'b0;
        end
      end
      ST_EVAL: begin
        rd_idx_next = '0;
        case (cmd_q.action)
          ACT_ALLOC: begin
            if (!size_fits) done_next = 1'b1;
          end
          ACT_FREE: begin
            div_go = owned;
            if (!owned) done_next = 1'b1;
          end
          ACT_LENGTH: begin
            done_next       = 1'b1;
            rsp_next.length = owned ? chunk_capacity : '0;
          end
          ACT_RESIZE: begin
            done_next   = 1'b1;
            rsp_next.ok = owned && size_fits;
          end
          ACT_RESET: begin
            clr_reply_next = 1'b1;
          end
          default: begin
            done_next = 1'b1;
          end
        endcase
      end
      ST_SCAN: begin
        pend_next = issue && !found;
        if (issue) rd_idx_next = rd_idx + N_W'(1);
        if (found) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx;
          mem_wdata = 1'b1;
        end else if (!issue && !pend) begin
          done_next = 1'b1;
        end
      end
      ST_GRANT_ADD: begin
        done_next               = 1'b1;
        rsp_next.ok             = 1'b1;
        rsp_next.result_address = base_address + 32'(prod_q) + 32'(HEADER_BYTES);
      end
      ST_DIV: begin
        if (div_done) begin
          done_next   = 1'b1;
          rsp_next.ok = free_hit;
          mem_we      = free_hit;
          mem_waddr   = div_quo[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      clr_reply <= 1'b0;
      pend      <= 1'b0;
      rd_idx    <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_reply <= clr_reply_next;
      pend      <= pend_next;
      rd_idx    <= rd_idx_next;
      done      <= done_next;
      if (state == ST_CLEAR) begin
        clr_idx <= (clr_idx == LAST_IDX) ? '0 : clr_idx + IDX_W'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= '0;
      chunk_capacity <= CAP_W'(64);
      chunk_count    <= COUNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:  base_address   <= cfg_data;
        REG_CAP:   chunk_capacity <= cfg_data[CAP_W-1:0];
        REG_COUNT: chunk_count    <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) cmd_q <= cmd;
    if (state == ST_DECODE) begin
      stride_q <= stride_now;
      span_q   <= SPAN_W'(n_eff) * SPAN_W'(stride_now);
    end
    if (state == ST_SCAN) chk_idx <= rd_idx[IDX_W-1:0];
    if (found) grant_idx <= chk_idx;
    if (state == ST_GRANT_MUL) prod_q <= PROD_W'(grant_idx) * PROD_W'(stride_q);
    result <= rsp_next;
  end

  // checks
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != ST_IDLE) else $error("result without a word in flight");

  a_map_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_SCAN || state == ST_DIV))
    else $error("free map written outside clear, scan or free");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV) else $error("divider finished outside free");

endmodule
